// ----- sv/ptb_pkg.sv -----
package ptb_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    localparam logic signed [31:0] ONE_Q30       = 32'sh4000_0000;
    localparam logic        [30:0] MIN_RES_RESET = 31'd1073742;
    localparam logic signed [63:0] MAX32         = 64'sd2147483647;
    localparam logic signed [63:0] MIN32         = -64'sd2147483648;

    // digit-by-digit square root state
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq;

    typedef struct packed {
        logic [31:0] rem;
        logic        qbit;
    } t_dv;

    typedef struct packed {
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] t1x;
        logic signed [31:0] t1y;
        logic signed [31:0] t1z;
        logic signed [31:0] t2x;
        logic signed [31:0] t2y;
        logic signed [31:0] t2z;
        logic               used_y;
        logic               zero;
    } t_res;

    function automatic t_sq sqrt_step(t_sq s, logic [1:0] pair);
        logic [35:0] acc;
        logic [35:0] trial;
        t_sq         n;
        acc   = {s.rem, pair};
        trial = {2'b00, s.root, 2'b01};
        if (acc >= trial) begin
            n.rem  = 34'(acc - trial);
            n.root = {s.root[30:0], 1'b1};
        end else begin
            n.rem  = acc[33:0];
            n.root = {s.root[30:0], 1'b0};
        end
        return n;
    endfunction

    function automatic t_dv div_step(logic [31:0] rem, logic bit_in, logic [31:0] d);
        logic [32:0] acc;
        t_dv         n;
        acc = {rem, bit_in};
        if (acc >= {1'b0, d}) begin
            n.rem  = 32'(acc - {1'b0, d});
            n.qbit = 1'b1;
        end else begin
            n.rem  = acc[31:0];
            n.qbit = 1'b0;
        end
        return n;
    endfunction

    // shift right by 30, round half away from zero
    function automatic logic signed [63:0] round_q30(logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] m;
        mag = v[63] ? 64'(-v) : 64'(v);
        m   = (mag + 64'h2000_0000) >> 30;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < MIN32) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- sv/ptb_if.sv -----
interface ptb_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    modport source(output valid, normal_x, normal_y, normal_z, input ready);
    modport sink(input valid, normal_x, normal_y, normal_z, output ready);
endinterface

interface ptb_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] unit_nx;
    logic signed [31:0] unit_ny;
    logic signed [31:0] unit_nz;
    logic signed [31:0] tan1_x;
    logic signed [31:0] tan1_y;
    logic signed [31:0] tan1_z;
    logic signed [31:0] tan2_x;
    logic signed [31:0] tan2_y;
    logic signed [31:0] tan2_z;
    logic               used_y_guess;
    logic               zero_normal;
    modport source(output valid, unit_nx, unit_ny, unit_nz, tan1_x, tan1_y, tan1_z,
                   tan2_x, tan2_y, tan2_z, used_y_guess, zero_normal, input ready);
    modport sink(input valid, unit_nx, unit_ny, unit_nz, tan1_x, tan1_y, tan1_z,
                 tan2_x, tan2_y, tan2_z, used_y_guess, zero_normal, output ready);
endinterface

// ----- sv/ptb_norm.sv -----
module ptb_norm #(
    parameter int SIDE_W = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_c [3],
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic signed [31:0] o_u [3],
    output logic [SIDE_W-1:0]  o_side
);
    import ptb_pkg::*;

    typedef struct packed {
        logic [2:0][31:0]  mg;
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } t_vec;

    typedef struct packed {
        t_vec        v;
        logic [63:0] x;
        t_sq         s;
    } t_sqs;

    typedef struct packed {
        logic [2:0][31:0]  rem;
        logic [2:0][30:0]  q;
        logic [2:0][30:0]  low;
        logic [31:0]       r;
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } t_dvs;

    logic        r_a_v, r_b_v, r_c_v, r_d_v, r_e_v, r_f_v, r_g_v, r_h_v;
    t_vec        r_a, r_b, r_c, r_d, r_e, r_f;
    t_vec        n_a, n_b, n_c, n_d;
    logic [31:0] r_b_max, n_b_max;
    logic [4:0]  r_c_k, n_c_k;
    logic [2:0][63:0] r_e_sq;
    logic [63:0] r_f_x;
    t_sqs        r_sq [SQRT_STEPS];
    logic        r_sq_v [SQRT_STEPS];
    t_dvs        r_g, n_g;
    t_dvs        r_dv [DIV_STEPS];
    logic        r_dv_v [DIV_STEPS];
    logic signed [31:0] r_h_u [3];
    logic [SIDE_W-1:0]  r_h_side;

    always_comb begin
        n_a.side = i_side;
        n_a.zero = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_a.neg[i] = i_c[i][31];
            n_a.mg[i]  = i_c[i][31] ? 32'(-i_c[i]) : 32'(i_c[i]);
        end
    end

    always_comb begin
        logic [31:0] m01;
        n_b     = r_a;
        m01     = (r_a.mg[0] > r_a.mg[1]) ? r_a.mg[0] : r_a.mg[1];
        n_b_max = (m01 > r_a.mg[2]) ? m01 : r_a.mg[2];
    end

    // smallest k that brings the largest magnitude up to 2^30
    always_comb begin
        n_c      = r_b;
        n_c.zero = (r_b_max == '0);
        n_c_k    = '0;
        for (int b = 0; b < 30; b++) begin
            if (r_b_max[b]) begin
                n_c_k = 5'(30 - b);
            end
        end
        if (r_b_max[31:30] != 2'b00) begin
            n_c_k = '0;
        end
    end

    always_comb begin
        n_d = r_c;
        for (int i = 0; i < 3; i++) begin
            n_d.mg[i] = r_c.mg[i] << r_c_k;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a     <= n_a;
            r_b     <= n_b;
            r_b_max <= n_b_max;
            r_c     <= n_c;
            r_c_k   <= n_c_k;
            r_d     <= n_d;
            r_e     <= r_d;
            for (int i = 0; i < 3; i++) begin
                r_e_sq[i] <= 64'(r_d.mg[i]) * 64'(r_d.mg[i]);
            end
            r_f     <= r_e;
            r_f_x   <= r_e_sq[0] + r_e_sq[1] + r_e_sq[2];
        end
    end

    // one root bit per stage, top pair first
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sq
        localparam int P = 2 * (SQRT_STEPS - 1 - j);
        t_sqs w_prev;
        logic w_prev_v;
        if (j == 0) begin : g_first
            assign w_prev   = '{v: r_f, x: r_f_x, s: '0};
            assign w_prev_v = r_f_v;
        end else begin : g_next
            assign w_prev   = r_sq[j-1];
            assign w_prev_v = r_sq_v[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j] <= 1'b0;
            end else if (i_en) begin
                r_sq_v[j] <= w_prev_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[j].v <= w_prev.v;
                r_sq[j].x <= w_prev.x;
                r_sq[j].s <= sqrt_step(w_prev.s, w_prev.x[P+1:P]);
            end
        end
    end

    // dividend = mg * 2^30 + r/2; quotient fits in 31 bits since mg <= r
    always_comb begin
        logic [61:0] d;
        n_g.r    = r_sq[SQRT_STEPS-1].s.root;
        n_g.neg  = r_sq[SQRT_STEPS-1].v.neg;
        n_g.zero = r_sq[SQRT_STEPS-1].v.zero;
        n_g.side = r_sq[SQRT_STEPS-1].v.side;
        n_g.q    = '0;
        for (int i = 0; i < 3; i++) begin
            d = {r_sq[SQRT_STEPS-1].v.mg[i][31:0], 30'b0}
                + 62'(r_sq[SQRT_STEPS-1].s.root[31:1]);
            n_g.rem[i] = {1'b0, d[61:31]};
            n_g.low[i] = d[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_g_v <= r_sq_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_g <= n_g;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_dv
        localparam int B = DIV_STEPS - 1 - j;
        t_dvs w_prev;
        logic w_prev_v;
        t_dvs w_next;
        if (j == 0) begin : g_first
            assign w_prev   = r_g;
            assign w_prev_v = r_g_v;
        end else begin : g_next
            assign w_prev   = r_dv[j-1];
            assign w_prev_v = r_dv_v[j-1];
        end
        always_comb begin
            t_dv st;
            w_next = w_prev;
            for (int i = 0; i < 3; i++) begin
                st = div_step(w_prev.rem[i], w_prev.low[i][B], w_prev.r);
                w_next.rem[i]  = st.rem;
                w_next.q[i][B] = st.qbit;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (i_en) begin
                r_dv_v[j] <= w_prev_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j] <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (i_en) begin
            r_h_v <= r_dv_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h_side <= r_dv[DIV_STEPS-1].side;
            for (int i = 0; i < 3; i++) begin
                if (r_dv[DIV_STEPS-1].zero) begin
                    r_h_u[i] <= '0;
                end else if (r_dv[DIV_STEPS-1].neg[i]) begin
                    r_h_u[i] <= -$signed({1'b0, r_dv[DIV_STEPS-1].q[i]});
                end else begin
                    r_h_u[i] <= $signed({1'b0, r_dv[DIV_STEPS-1].q[i]});
                end
            end
        end
    end

    assign o_valid = r_h_v;
    assign o_u     = r_h_u;
    assign o_side  = r_h_side;

endmodule

// ----- sv/plane_tangent_basis.sv -----
// channel  | dir | handshake          | word
// i_in     | in  | valid/ready        | normal_x/y/z, Q16.16
// o_out    | out | valid/ready        | unit n, tan1, tan2 (Q2.30), used_y_guess, zero_normal
// cfg      | in  | i_cfg_we (no wait) | min_residual_norm, 31 bits
//
// One word per cycle in and out while the receiver keeps o_out.ready high; the latency is set
// by the three square roots and the two normalizing dividers, each a one-bit-per-stage
// pipeline.
// Reset (synchronous, active low) clears all valid bits and loads the threshold.
// A two-word output queue parts the sides: the pipeline freezes only when it is full,
// so i_in.ready depends on registers alone.
module plane_tangent_basis (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ptb_in_if.sink          i_in,
    ptb_out_if.source       o_out,
    input  logic            i_cfg_we,
    input  logic [30:0]     i_cfg_wdata
);
    import ptb_pkg::*;

    localparam int SIDE2_W = 3 * 32 + 3;
    localparam logic [1:0] QDEPTH = 2'd2;

    typedef struct packed {
        logic [2:0][31:0] n;
        logic [4:0][63:0] p;   // n0n0 n0n1 n0n2 n1n1 n1n2
        logic             zero;
    } t_p1;

    typedef struct packed {
        logic [2:0][31:0] n;
        logic [2:0][31:0] tx;
        logic [2:0][31:0] ty;
        logic             zero;
    } t_p2;

    typedef struct packed {
        t_p2         v;
        logic [63:0] x;
        t_sq         s;
    } t_ln;

    typedef struct packed {
        logic [2:0][31:0] n;
        logic [2:0][31:0] t1;
        logic             used_y;
        logic             zero;
    } t_x0;

    typedef struct packed {
        logic [2:0][31:0] n;
        logic [2:0][31:0] t1;
        logic [5:0][63:0] p;
        logic             used_y;
        logic             zero;
    } t_x1;

    typedef struct packed {
        logic [2:0][31:0] n;
        logic [2:0][31:0] t1;
        logic [2:0][63:0] d;
        logic             used_y;
        logic             zero;
    } t_x2;

    logic        w_en;
    logic [30:0] r_min_res;

    logic               w_n1_v;
    logic signed [31:0] w_n1_c [3];
    logic signed [31:0] w_n1_u [3];
    logic [0:0]         w_n1_side;

    logic        r_p1_v, r_p2_v, r_p3_v, r_p4_v, r_c_v, r_x0_v, r_x1_v, r_x2_v;
    t_p1         r_p1, n_p1;
    t_p2         r_p2, n_p2, r_p3, r_p4;
    logic [2:0][63:0] r_p3_sq;
    logic [63:0] r_p4_x;
    t_ln         r_ln [SQRT_STEPS];
    logic        r_ln_v [SQRT_STEPS];

    logic signed [31:0] r_c_t [3];
    logic [SIDE2_W-1:0] r_c_side, n_c_side;
    logic signed [31:0] n_c_t [3];

    logic               w_n2_v;
    logic signed [31:0] w_n2_u [3];
    logic [SIDE2_W-1:0] w_n2_side;

    t_x0  r_x0, n_x0;
    t_x1  r_x1, n_x1;
    t_x2  r_x2, n_x2;
    t_res w_res;

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    // pipeline moves while the output queue has room
    assign w_en = (r_cnt != QDEPTH);
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_res <= MIN_RES_RESET;
        end else if (i_cfg_we) begin
            r_min_res <= i_cfg_wdata;
        end
    end

    assign w_n1_c[0] = i_in.normal_x;
    assign w_n1_c[1] = i_in.normal_y;
    assign w_n1_c[2] = i_in.normal_z;

    ptb_norm #(.SIDE_W(1)) u_norm_n (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_c     (w_n1_c),
        .i_side  (1'((i_in.normal_x == '0) && (i_in.normal_y == '0)
                     && (i_in.normal_z == '0))),
        .o_valid (w_n1_v),
        .o_u     (w_n1_u),
        .o_side  (w_n1_side)
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_p1.n[i] = w_n1_u[i];
        end
        n_p1.zero = w_n1_side[0];
        n_p1.p[0] = 64'(64'(w_n1_u[0]) * 64'(w_n1_u[0]));
        n_p1.p[1] = 64'(64'(w_n1_u[0]) * 64'(w_n1_u[1]));
        n_p1.p[2] = 64'(64'(w_n1_u[0]) * 64'(w_n1_u[2]));
        n_p1.p[3] = 64'(64'(w_n1_u[1]) * 64'(w_n1_u[1]));
        n_p1.p[4] = 64'(64'(w_n1_u[1]) * 64'(w_n1_u[2]));
    end

    // remainders of the x and y axes after removing the normal part
    always_comb begin
        logic signed [63:0] r0, r1, r2, r3, r4;
        r0 = round_q30($signed(r_p1.p[0]));
        r1 = round_q30($signed(r_p1.p[1]));
        r2 = round_q30($signed(r_p1.p[2]));
        r3 = round_q30($signed(r_p1.p[3]));
        r4 = round_q30($signed(r_p1.p[4]));
        n_p2.n     = r_p1.n;
        n_p2.zero  = r_p1.zero;
        n_p2.tx[0] = 32'(ONE_Q30 - r0[31:0]);
        n_p2.tx[1] = 32'(-r1[31:0]);
        n_p2.tx[2] = 32'(-r2[31:0]);
        n_p2.ty[0] = 32'(-r1[31:0]);
        n_p2.ty[1] = 32'(ONE_Q30 - r3[31:0]);
        n_p2.ty[2] = 32'(-r4[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
            r_p4_v <= 1'b0;
        end else if (w_en) begin
            r_p1_v <= w_n1_v;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            r_p4_v <= r_p3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_p3 <= r_p2;
            for (int i = 0; i < 3; i++) begin
                r_p3_sq[i] <= 64'(64'($signed(r_p2.tx[i])) * 64'($signed(r_p2.tx[i])));
            end
            r_p4   <= r_p3;
            r_p4_x <= r_p3_sq[0] + r_p3_sq[1] + r_p3_sq[2];
        end
    end

    // length of the x remainder
    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_ln
        localparam int P = 2 * (SQRT_STEPS - 1 - j);
        t_ln  w_prev;
        logic w_prev_v;
        if (j == 0) begin : g_first
            assign w_prev   = '{v: r_p4, x: r_p4_x, s: '0};
            assign w_prev_v = r_p4_v;
        end else begin : g_next
            assign w_prev   = r_ln[j-1];
            assign w_prev_v = r_ln_v[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ln_v[j] <= 1'b0;
            end else if (w_en) begin
                r_ln_v[j] <= w_prev_v;
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ln[j].v <= w_prev.v;
                r_ln[j].x <= w_prev.x;
                r_ln[j].s <= sqrt_step(w_prev.s, w_prev.x[P+1:P]);
            end
        end
    end

    always_comb begin
        t_p2  v;
        logic nxz;
        logic use_y;
        v     = r_ln[SQRT_STEPS-1].v;
        nxz   = (v.n[0] == '0);
        use_y = !nxz && !v.zero && (r_ln[SQRT_STEPS-1].s.root < {1'b0, r_min_res});
        for (int i = 0; i < 3; i++) begin
            n_c_t[i] = use_y ? v.ty[i] : v.tx[i];
        end
        n_c_side = {v.n, use_y, v.zero, nxz};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_ln_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_t    <= n_c_t;
            r_c_side <= n_c_side;
        end
    end

    ptb_norm #(.SIDE_W(SIDE2_W)) u_norm_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_c_v),
        .i_c     (r_c_t),
        .i_side  (r_c_side),
        .o_valid (w_n2_v),
        .o_u     (w_n2_u),
        .o_side  (w_n2_side)
    );

    // side word: n[2:0], used_y, zero, nx is zero
    always_comb begin
        n_x0.n      = w_n2_side[SIDE2_W-1:3];
        n_x0.used_y = w_n2_side[2];
        n_x0.zero   = w_n2_side[1];
        for (int i = 0; i < 3; i++) begin
            n_x0.t1[i] = w_n2_u[i];
        end
        if (w_n2_side[1]) begin
            n_x0.t1 = '0;
        end else if (w_n2_side[0]) begin
            n_x0.t1 = {32'sd0, 32'sd0, ONE_Q30};
        end
    end

    // index 0 is x, 2 is z, for both n and t1
    always_comb begin
        logic signed [31:0] nx, ny, nz, tx, ty, tz;
        nx = r_x0.n[0];
        ny = r_x0.n[1];
        nz = r_x0.n[2];
        tx = r_x0.t1[0];
        ty = r_x0.t1[1];
        tz = r_x0.t1[2];
        n_x1.n      = r_x0.n;
        n_x1.t1     = r_x0.t1;
        n_x1.used_y = r_x0.used_y;
        n_x1.zero   = r_x0.zero;
        n_x1.p[0]   = 64'(64'(ny) * 64'(tz));
        n_x1.p[1]   = 64'(64'(nz) * 64'(ty));
        n_x1.p[2]   = 64'(64'(nz) * 64'(tx));
        n_x1.p[3]   = 64'(64'(nx) * 64'(tz));
        n_x1.p[4]   = 64'(64'(nx) * 64'(ty));
        n_x1.p[5]   = 64'(64'(ny) * 64'(tx));
    end

    always_comb begin
        n_x2.n      = r_x1.n;
        n_x2.t1     = r_x1.t1;
        n_x2.used_y = r_x1.used_y;
        n_x2.zero   = r_x1.zero;
        n_x2.d[2]   = r_x1.p[0] - r_x1.p[1];
        n_x2.d[1]   = r_x1.p[2] - r_x1.p[3];
        n_x2.d[0]   = r_x1.p[4] - r_x1.p[5];
    end

    always_comb begin
        w_res.nx     = r_x2.n[0];
        w_res.ny     = r_x2.n[1];
        w_res.nz     = r_x2.n[2];
        w_res.t1x    = r_x2.t1[0];
        w_res.t1y    = r_x2.t1[1];
        w_res.t1z    = r_x2.t1[2];
        w_res.t2x    = sat32(round_q30($signed(r_x2.d[2])));
        w_res.t2y    = sat32(round_q30($signed(r_x2.d[1])));
        w_res.t2z    = sat32(round_q30($signed(r_x2.d[0])));
        w_res.used_y = r_x2.used_y;
        w_res.zero   = r_x2.zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x0_v <= 1'b0;
            r_x1_v <= 1'b0;
            r_x2_v <= 1'b0;
        end else if (w_en) begin
            r_x0_v <= w_n2_v;
            r_x1_v <= r_x0_v;
            r_x2_v <= r_x1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0 <= n_x0;
            r_x1 <= n_x1;
            r_x2 <= n_x2;
        end
    end

    // output queue
    assign w_push = r_x2_v && w_en;
    assign w_pop  = (r_cnt != 2'd0) && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= 2'(r_cnt + 2'(w_push) - 2'(w_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_res;
        end
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.unit_nx      = r_q[r_rp].nx;
    assign o_out.unit_ny      = r_q[r_rp].ny;
    assign o_out.unit_nz      = r_q[r_rp].nz;
    assign o_out.tan1_x       = r_q[r_rp].t1x;
    assign o_out.tan1_y       = r_q[r_rp].t1y;
    assign o_out.tan1_z       = r_q[r_rp].t1z;
    assign o_out.tan2_x       = r_q[r_rp].t2x;
    assign o_out.tan2_y       = r_q[r_rp].t2y;
    assign o_out.tan2_z       = r_q[r_rp].t2z;
    assign o_out.used_y_guess = r_q[r_rp].used_y;
    assign o_out.zero_normal  = r_q[r_rp].zero;

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QDEPTH)
        else $error("output queue overflow");

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_normal |->
            o_out.unit_nx == '0 && o_out.unit_ny == '0 && o_out.unit_nz == '0 &&
            o_out.tan1_x == '0 && o_out.tan1_y == '0 && o_out.tan1_z == '0 &&
            o_out.tan2_x == '0 && o_out.tan2_y == '0 && o_out.tan2_z == '0 &&
            !o_out.used_y_guess)
        else $error("zero normal with nonzero frame");

    a_x_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.zero_normal && o_out.unit_nx == '0 |->
            o_out.tan1_x == ONE_Q30 && o_out.tan1_y == '0 && o_out.tan1_z == '0 &&
            !o_out.used_y_guess)
        else $error("x axis tangent expected");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == QDEPTH && !o_out.ready |=> r_cnt == QDEPTH)
        else $error("queue changed while full and stalled");

endmodule

// ----- bench/ptb_basis_checker.sv -----
`timescale 1ns / 100ps

module ptb_basis_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptb_in_if           i_in,
    ptb_out_if          i_out,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);
    import ptb_pkg::*;

    typedef logic [2:0][63:0] vec3_t;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    logic [30:0] threshold;
    t_res        frame_q[$];

    function automatic logic [63:0] root64(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b   = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [63:0] rnd30(logic signed [63:0] v);
        logic [63:0] m;
        m = ((v < 0 ? -v : v) + (64'd1 << 29)) >> 30;
        return v < 0 ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic vec3_t unitize(vec3_t c);
        logic [2:0][63:0] mg;
        logic [63:0]      m;
        logic [63:0]      s;
        logic [63:0]      r;
        logic [63:0]      q;
        vec3_t            u;
        int               k;
        m = 0;
        s = 0;
        k = 0;
        u = '0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = $signed(c[i]) < 0 ? -c[i] : c[i];
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) return u;
        while ((m << k) < Q30_ONE) k++;
        for (int i = 0; i < 3; i++) begin
            mg[i] = mg[i] << k;
            s     = s + mg[i] * mg[i];
        end
        r = root64(s);
        for (int i = 0; i < 3; i++) begin
            q    = ((mg[i] << 30) + (r >> 1)) / r;
            u[i] = $signed(c[i]) < 0 ? -q : q;
        end
        return u;
    endfunction

    // axis minus its projection onto the unit normal
    function automatic vec3_t axis_residual(vec3_t n, int axis);
        vec3_t t;
        for (int i = 0; i < 3; i++)
            t[i] = (i == axis ? Q30_ONE : 64'd0) - rnd30($signed(n[axis]) * $signed(n[i]));
        return t;
    endfunction

    function automatic t_res predict_frame(logic signed [31:0] cx, logic signed [31:0] cy,
                                           logic signed [31:0] cz, logic [30:0] thr);
        vec3_t       c;
        vec3_t       n;
        vec3_t       t;
        vec3_t       t1;
        logic [63:0] len;
        t_res        r;
        r = '0;
        if (cx == 0 && cy == 0 && cz == 0) begin
            r.zero = 1'b1;
            return r;
        end
        c[0] = 64'(cx);
        c[1] = 64'(cy);
        c[2] = 64'(cz);
        n = unitize(c);
        if (n[0] == 0) begin
            t1 = '0;
            t1[0] = Q30_ONE;
        end else begin
            t   = axis_residual(n, 0);
            len = root64(t[0] * t[0] + t[1] * t[1] + t[2] * t[2]);
            if (len < {33'd0, thr}) begin
                r.used_y = 1'b1;
                t = axis_residual(n, 1);
            end
            t1 = unitize(t);
        end
        r.nx  = clamp32(n[0]);
        r.ny  = clamp32(n[1]);
        r.nz  = clamp32(n[2]);
        r.t1x = clamp32(t1[0]);
        r.t1y = clamp32(t1[1]);
        r.t1z = clamp32(t1[2]);
        r.t2x = clamp32(rnd30($signed(n[1]) * $signed(t1[2]) - $signed(n[2]) * $signed(t1[1])));
        r.t2y = clamp32(rnd30($signed(n[2]) * $signed(t1[0]) - $signed(n[0]) * $signed(t1[2])));
        r.t2z = clamp32(rnd30($signed(n[0]) * $signed(t1[1]) - $signed(n[1]) * $signed(t1[0])));
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    assign o_pending = frame_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        t_res exp_f;
        if (!i_rst_n) begin
            threshold <= MIN_RES_RESET;
        end else begin
            if (i_cfg_we) begin
                threshold <= i_cfg_wdata;
            end
            if (i_in.valid && i_in.ready) begin
                frame_q.push_back(predict_frame(i_in.normal_x, i_in.normal_y,
                                                i_in.normal_z, threshold));
            end
            if (i_out.valid && i_out.ready) begin
                if (frame_q.size() == 0) begin
                    $display("%0t: unexpected output word, got nx=%h", $time, i_out.unit_nx);
                    o_fail_count++;
                end else begin
                    exp_f = frame_q.pop_front();
                    check_field("unit_nx", exp_f.nx, i_out.unit_nx);
                    check_field("unit_ny", exp_f.ny, i_out.unit_ny);
                    check_field("unit_nz", exp_f.nz, i_out.unit_nz);
                    check_field("tan1_x", exp_f.t1x, i_out.tan1_x);
                    check_field("tan1_y", exp_f.t1y, i_out.tan1_y);
                    check_field("tan1_z", exp_f.t1z, i_out.tan1_z);
                    check_field("tan2_x", exp_f.t2x, i_out.tan2_x);
                    check_field("tan2_y", exp_f.t2y, i_out.tan2_y);
                    check_field("tan2_z", exp_f.t2z, i_out.tan2_z);
                    check_field("used_y_guess", 32'(exp_f.used_y), 32'(i_out.used_y_guess));
                    check_field("zero_normal", 32'(exp_f.zero), 32'(i_out.zero_normal));
                end
            end
        end
    end

endmodule

// ----- bench/tb_plane_tangent_basis.sv -----
`timescale 1ns / 100ps

module tb_plane_tangent_basis;
    import ptb_pkg::*;

    localparam int DRAIN_CYCLES = 250;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [30:0] cfg_wdata;
    int          fail_count;
    int          frames_pending;
    int          burst_left;
    int          stall_cnt;
    int          stall_mode;

    ptb_in_if  in_ch();
    ptb_out_if out_ch();

    plane_tangent_basis u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    ptb_basis_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (frames_pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // receiver: stall_mode is redrawn at random from four modes, one of which never stalls
    initial begin
        out_ch.ready = 1'b0;
        stall_cnt    = 0;
        stall_mode   = 0;
    end
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 64 == 63) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: begin
                out_ch.ready <= 1'b1;
            end
            1: begin
                out_ch.ready <= $urandom_range(0, 1);
            end
            2: begin
                out_ch.ready <= (stall_cnt % 8) != 0;
            end
            default: begin
                out_ch.ready <= (stall_cnt % 16) < 3;
            end
        endcase
    end

    task automatic send_normal(logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z);
        if (burst_left == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        in_ch.valid    <= 1'b1;
        in_ch.normal_x <= x;
        in_ch.normal_y <= y;
        in_ch.normal_z <= z;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    task automatic set_threshold(logic [30:0] v);
        in_ch.valid <= 1'b0;
        while (frames_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $signed($urandom) >>> $urandom_range(0, 31);
            2: v = $signed($urandom_range(0, 512)) - 256;
            3: v = 0;
            4: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic random_normals(int count);
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        for (int i = 0; i < count; i++) begin
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            // nearly x-aligned normals reach the y-axis fallback
            if ($urandom_range(0, 3) == 0) begin
                x = $urandom_range(1 << 20, 32'h7FFF_FFFF);
                if ($urandom_range(0, 1)) x = -x;
                y = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
                z = $signed($urandom_range(0, 1 << 12)) - (1 << 11);
            end
            send_normal(x, y, z);
        end
    endtask

    task automatic directed_normals();
        send_normal(0, 0, 0);
        send_normal(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_normal(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        send_normal(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_normal(32'sh0001_0000, 0, 0);
        send_normal(-32'sh0001_0000, 0, 0);
        send_normal(1, 0, 0);
        send_normal(0, 32'sh0001_0000, 0);
        send_normal(0, 0, -1);
        send_normal(0, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_normal(1, 1, 1);
        send_normal(-1, 1, -1);
        send_normal(32'sh4000_0000, 3, -5);
        send_normal(32'sh7FFF_FFFF, 1, 0);
        send_normal(32'sh0001_0000, 32'sh0001_0000, 0);
        send_normal(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        in_ch.valid    = 1'b0;
        in_ch.normal_x = '0;
        in_ch.normal_y = '0;
        in_ch.normal_z = '0;
        burst_left     = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_normals();
        random_normals(300);

        set_threshold(31'd0);
        directed_normals();
        random_normals(150);

        set_threshold(31'h4000_0000);
        directed_normals();
        random_normals(100);

        set_threshold(31'h7FFF_FFFF);
        directed_normals();
        random_normals(100);

        set_threshold($urandom_range(1, 1 << 24));
        random_normals(250);

        set_threshold(MIN_RES_RESET);
        random_normals(100);

        in_ch.valid <= 1'b0;
        while (frames_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && frames_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- plane_tangent_basis.f -----
sv/ptb_pkg.sv
sv/ptb_if.sv
sv/ptb_norm.sv
sv/plane_tangent_basis.sv
bench/ptb_basis_checker.sv
bench/tb_plane_tangent_basis.sv
